// File: src/smirnov_two_sample_exact_cdf_unit_macros.svh
// Assertion macros shared by the exact Smirnov distribution unit.
`ifndef SMIRNOV_TWO_SAMPLE_EXACT_CDF_UNIT_MACROS_SVH
`define SMIRNOV_TWO_SAMPLE_EXACT_CDF_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STSECDF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stsecdf assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STSECDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stsecdf assertion failed");

`endif

// File: src/stsecdf_pkg.sv
// Package with field widths, defaults and payload types of the Smirnov distribution unit.
package stsecdf_pkg;

   localparam int DEF_MAX_SAMPLE = 1024;
   localparam int DEF_FRAC_BITS  = 48;

   localparam int COUNT_W = 11;
   localparam int STAT_W  = 21;
   localparam int PROB_W  = 49;

   typedef struct packed {
      logic [COUNT_W-1:0] sample_count_a;
      logic [COUNT_W-1:0] sample_count_b;
      logic [STAT_W-1:0]  statistic_scaled;
   } req_payload_type;

   typedef struct packed {
      logic [PROB_W-1:0] cdf;
      logic [PROB_W-1:0] p_value;
   } rsp_payload_type;

   // Sideband that travels with one lattice cell through the multiplier.
   typedef struct packed {
      logic kill;
      logic first;
      logic last;
   } cell_tag_type;

endpackage

// File: src/stsecdf_if.sv
// Valid/ready channel interfaces for the request and response items.
interface stsecdf_req_if;
   logic                         valid;
   logic                         ready;
   stsecdf_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface stsecdf_rsp_if;
   logic                         valid;
   logic                         ready;
   stsecdf_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/stsecdf_frac_div.sv
// Restoring divider that forms floor(num * 2^FRAC_BITS / den), one quotient bit per cycle.
module stsecdf_frac_div #(
   parameter int NUM_W     = 11,
   parameter int FRAC_BITS = stsecdf_pkg::DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_W-1:0]     num,
   input  logic [NUM_W:0]       den,
   output logic                 done,
   output logic [FRAC_BITS-1:0] quotient
);

   localparam int REM_W = NUM_W + 2;
   localparam int CNT_W = $clog2(FRAC_BITS);

   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [FRAC_BITS-1:0] q_ff, q_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [REM_W-1:0]     rem_shift;
   logic [REM_W-1:0]     den_ext;

   assign rem_shift = {rem_ff[REM_W-2:0], 1'b0};
   assign den_ext   = REM_W'(den);

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = REM_W'(num);
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_shift >= den_ext) begin
            rem_in = rem_shift - den_ext;
            q_in   = {q_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            q_in   = {q_ff[FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(FRAC_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// File: src/stsecdf_fx_mul.sv
// Two-stage rounded fixed-point multiplier built from four half-width partial products.
module stsecdf_fx_mul #(
   parameter int FRAC_BITS = stsecdf_pkg::DEF_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  stsecdf_pkg::cell_tag_type in_tag,
   input  logic [FRAC_BITS:0]        a,
   input  logic [FRAC_BITS:0]        b,
   output logic                      out_valid,
   output stsecdf_pkg::cell_tag_type out_tag,
   output logic [FRAC_BITS:0]        product
);

   localparam int Q_W = FRAC_BITS + 1;
   localparam int L_W = (Q_W + 1) / 2;
   localparam int H_W = Q_W - L_W;
   localparam int S_W = 2 * Q_W + 1;

   logic [2*L_W-1:0]     ll_ff;
   logic [L_W+H_W-1:0]   lh_ff, hl_ff;
   logic [2*H_W-1:0]     hh_ff;
   logic                 v1_ff, v2_ff;
   stsecdf_pkg::cell_tag_type tag1_ff, tag2_ff;
   logic [Q_W-1:0]       prod_ff, prod_in;
   logic [S_W-1:0]       sum_w;

   always_ff @(posedge clock) begin
      ll_ff   <= a[L_W-1:0] * b[L_W-1:0];
      lh_ff   <= (L_W+H_W)'(a[L_W-1:0]) * (L_W+H_W)'(b[Q_W-1:L_W]);
      hl_ff   <= (L_W+H_W)'(a[Q_W-1:L_W]) * (L_W+H_W)'(b[L_W-1:0]);
      hh_ff   <= a[Q_W-1:L_W] * b[Q_W-1:L_W];
      tag1_ff <= in_tag;
      tag2_ff <= tag1_ff;
      prod_ff <= prod_in;
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   // Full product plus one half LSB of the result, then the fraction is dropped.
   always_comb begin
      sum_w = S_W'(ll_ff)
            + (S_W'(lh_ff) << L_W)
            + (S_W'(hl_ff) << L_W)
            + (S_W'(hh_ff) << (2 * L_W))
            + (S_W'(1) << (FRAC_BITS - 1));
      prod_in = sum_w[FRAC_BITS +: Q_W];
   end

   assign out_valid = v2_ff;
   assign out_tag   = tag2_ff;
   assign product   = prod_ff;

endmodule

// File: src/smirnov_two_sample_exact_cdf_unit.sv
// Top level of the exact two-sample Smirnov distribution unit.
//
//   channel   direction  fields                                              handshake
//   req_chan  in         sample_count_a, sample_count_b, statistic_scaled     valid/ready
//   rsp_chan  out        cdf, p_value                                        valid/ready
//
// The sizes are ordered so that m <= n. The next item can be taken in the same cycle
// as the previous result becomes valid on the output.
// Row zero is written first, n+1 cells in all, then each row runs the bit-serial weight divider
// and sweeps n+1 cells through the one-read one-write row memory and the multiplier.
// The memory needs no clearing after reset; every row is written before it is read.
// A new item is taken only in idle; a finished result waits in the output register,
// and the unit stalls at the end of an item until the previous result is taken.
module smirnov_two_sample_exact_cdf_unit #(
   parameter int MAX_SAMPLE = stsecdf_pkg::DEF_MAX_SAMPLE,
   parameter int FRAC_BITS  = stsecdf_pkg::DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   stsecdf_req_if.sink          req_chan,
   stsecdf_rsp_if.source        rsp_chan
);

   `include "smirnov_two_sample_exact_cdf_unit_macros.svh"

   localparam int IDX_W  = $clog2(MAX_SAMPLE + 1);
   localparam int CW     = (IDX_W > stsecdf_pkg::COUNT_W) ? IDX_W : stsecdf_pkg::COUNT_W;
   localparam int PROD_W = 2 * IDX_W;
   localparam int CMP_W  = (PROD_W > stsecdf_pkg::STAT_W) ? PROD_W : stsecdf_pkg::STAT_W;
   localparam int Q_W    = FRAC_BITS + 1;
   localparam int OUT_W  = stsecdf_pkg::PROB_W;
   localparam int EXT_W  = (Q_W > OUT_W) ? Q_W : OUT_W;
   localparam logic [Q_W-1:0] Q_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [2:0] {
      ST_IDLE, ST_INIT, ST_SETUP, ST_DIVW, ST_SWEEP, ST_DRAIN, ST_FINISH
   } state_type;

   function automatic logic [IDX_W-1:0] clamp_size(input logic [stsecdf_pkg::COUNT_W-1:0] s);
      logic [CW-1:0] se;
      logic [CW-1:0] r;
      se = CW'(s);
      if (se == '0) begin
         r = CW'(1);
      end else if (se > CW'(MAX_SAMPLE)) begin
         r = CW'(MAX_SAMPLE);
      end else begin
         r = se;
      end
      return r[IDX_W-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      m_ff, m_in, n_ff, n_in;
   logic [stsecdf_pkg::STAT_W-1:0] d_ff, d_in;
   logic [IDX_W-1:0]      row_ff, row_in, col_ff, col_in, wcol_ff, wcol_in;
   logic [PROD_W-1:0]     in_ff, in_in, jm_ff, jm_in;
   logic [Q_W-1:0]        w_ff, w_in, left_ff, left_in, res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]        rsp_cdf_ff, rsp_cdf_in, rsp_p_ff, rsp_p_in;

   logic [Q_W-1:0]        path_row [MAX_SAMPLE+1];
   logic [Q_W-1:0]        rd_data_ff;
   logic                  rd_valid_ff;
   stsecdf_pkg::cell_tag_type rd_tag_ff, iss_tag;

   logic                  mem_wr_en;
   logic [IDX_W-1:0]      mem_wr_addr;
   logic [Q_W-1:0]        mem_wr_data;

   logic                  div_start, div_done;
   logic [FRAC_BITS-1:0]  div_q;
   logic [IDX_W:0]        div_den;

   logic                  mul_out_valid;
   stsecdf_pkg::cell_tag_type mul_out_tag;
   logic [Q_W-1:0]        mul_prod;

   logic [PROD_W-1:0]     lattice_dist;
   logic [Q_W:0]          cell_sum;
   logic [Q_W-1:0]        cell_val;
   logic [IDX_W-1:0]      a_clamped, b_clamped;
   logic [EXT_W-1:0]      cdf_ext, p_ext;
   logic                  row_active;
   logic                  req_accept;

   assign a_clamped = clamp_size(req_chan.payload.sample_count_a);
   assign b_clamped = clamp_size(req_chan.payload.sample_count_b);

   // Lattice distance |i*n - j*m| from the running row and column products.
   assign lattice_dist = (in_ff > jm_ff) ? (in_ff - jm_ff) : (jm_ff - in_ff);
   always_comb begin
      iss_tag.kill  = (CMP_W'(lattice_dist) >= CMP_W'(d_ff));
      iss_tag.first = (col_ff == '0);
      iss_tag.last  = (col_ff == n_ff);
   end

   // New cell: weighted cell above plus the new cell to its left, saturated at one; zero for a killed cell.
   always_comb begin
      cell_sum = {1'b0, mul_prod} + (mul_out_tag.first ? '0 : {1'b0, left_ff});
      if (mul_out_tag.kill) begin
         cell_val = '0;
      end else if (cell_sum > {1'b0, Q_ONE}) begin
         cell_val = Q_ONE;
      end else begin
         cell_val = cell_sum[Q_W-1:0];
      end
   end

   always_comb begin
      if (state_ff == ST_INIT) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = col_ff;
         mem_wr_data = (CMP_W'(jm_ff) >= CMP_W'(d_ff)) ? '0 : Q_ONE;
      end else begin
         mem_wr_en   = mul_out_valid;
         mem_wr_addr = wcol_ff;
         mem_wr_data = cell_val;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         path_row[mem_wr_addr] <= mem_wr_data;
      end
      rd_data_ff <= path_row[col_ff];
   end

   assign div_start = (state_ff == ST_SETUP);
   assign div_den   = {1'b0, row_ff} + {1'b0, n_ff};

   stsecdf_frac_div #(
      .NUM_W     (IDX_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (row_ff),
      .den      (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   stsecdf_fx_mul #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .in_tag    (rd_tag_ff),
      .a         (w_ff),
      .b         (rd_data_ff),
      .out_valid (mul_out_valid),
      .out_tag   (mul_out_tag),
      .product   (mul_prod)
   );

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      in_in        = in_ff;
      jm_in        = jm_ff;
      w_in         = w_ff;
      res_in       = res_ff;
      wcol_in      = mul_out_valid ? (wcol_ff + IDX_W'(1)) : wcol_ff;
      left_in      = mul_out_valid ? cell_val : left_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_cdf_in   = rsp_cdf_ff;
      rsp_p_in     = rsp_p_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               if (a_clamped > b_clamped) begin
                  m_in = b_clamped;
                  n_in = a_clamped;
               end else begin
                  m_in = a_clamped;
                  n_in = b_clamped;
               end
               d_in     = req_chan.payload.statistic_scaled;
               col_in   = '0;
               jm_in    = '0;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            col_in = col_ff + IDX_W'(1);
            jm_in  = jm_ff + PROD_W'(m_ff);
            if (col_ff == n_ff) begin
               row_in   = IDX_W'(1);
               in_in    = PROD_W'(n_ff);
               col_in   = '0;
               jm_in    = '0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            wcol_in  = '0;
            state_in = ST_DIVW;
         end
         ST_DIVW: begin
            if (div_done) begin
               w_in     = Q_W'(div_q);
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            col_in = col_ff + IDX_W'(1);
            jm_in  = jm_ff + PROD_W'(m_ff);
            if (col_ff == n_ff) begin
               col_in   = '0;
               jm_in    = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mul_out_valid && mul_out_tag.last) begin
               if (row_ff == m_ff) begin
                  res_in   = cell_val;
                  state_in = ST_FINISH;
               end else begin
                  row_in   = row_ff + IDX_W'(1);
                  in_in    = in_ff + PROD_W'(n_ff);
                  state_in = ST_SETUP;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_cdf_in   = res_ff;
               rsp_p_in     = Q_ONE - res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      m_ff       <= m_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      in_ff      <= in_in;
      jm_ff      <= jm_in;
      w_ff       <= w_in;
      left_ff    <= left_in;
      res_ff     <= res_in;
      rsp_cdf_ff <= rsp_cdf_in;
      rsp_p_ff   <= rsp_p_in;
      rd_tag_ff  <= iss_tag;
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         wcol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         wcol_ff      <= wcol_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= (state_ff == ST_SWEEP);
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign cdf_ext = EXT_W'(rsp_cdf_ff);
   assign p_ext   = EXT_W'(rsp_p_ff);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.payload.cdf     = cdf_ext[OUT_W-1:0];
   assign rsp_chan.payload.p_value = p_ext[OUT_W-1:0];

   assign row_active = (state_ff == ST_SWEEP) || (state_ff == ST_DRAIN);
   assign req_accept = req_chan.valid && req_chan.ready;

   `STSECDF_ASSERT_SAME(a_cell_at_most_one, clock, reset, mem_wr_en, mem_wr_data <= Q_ONE)
   `STSECDF_ASSERT_SAME(a_pipe_only_in_row, clock, reset, mul_out_valid, row_active)
   `STSECDF_ASSERT_SAME(a_result_sums_to_one, clock, reset, rsp_valid_ff, rsp_cdf_ff + rsp_p_ff == Q_ONE)
   `STSECDF_ASSERT_NEXT(a_accept_starts_init, clock, reset, req_accept, state_ff == ST_INIT)

endmodule

// File: tb/sv/smirnov_cdf_checker.sv
// Checker that predicts the exact Smirnov distribution of every request item and compares responses.
module smirnov_cdf_checker
   import stsecdf_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   stsecdf_req_if req_chan,
   stsecdf_rsp_if rsp_chan,
   output int     mismatch_count,
   output int     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] Q_ONE = 64'd1 << DEF_FRAC_BITS;

   // One lattice row, reused in place row after row.
   logic [63:0] lattice_row [0:DEF_MAX_SAMPLE];

   rsp_payload_type cdf_expected_q [$];

   function automatic logic [63:0] clamp_size(logic [COUNT_W-1:0] raw);
      if (raw == '0) return 64'd1;
      if (raw > DEF_MAX_SAMPLE) return 64'(DEF_MAX_SAMPLE);
      return 64'(raw);
   endfunction

   function automatic rsp_payload_type predict_cdf(req_payload_type item);
      logic [63:0]     m, n, d, t, i, j, weight, offset, node, prob;
      logic [127:0]    prod;
      rsp_payload_type res;
      m = clamp_size(item.sample_count_a);
      n = clamp_size(item.sample_count_b);
      d = 64'(item.statistic_scaled);
      if (m > n) begin
         t = m;
         m = n;
         n = t;
      end
      // Cells of row zero are reachable only while j*m stays below d.
      for (j = 0; j <= n; j++) begin
         lattice_row[j] = (j * m >= d) ? 64'd0 : Q_ONE;
      end
      for (i = 1; i <= m; i++) begin
         weight = (i << DEF_FRAC_BITS) / (i + n);
         for (j = 0; j <= n; j++) begin
            offset = (i * n > j * m) ? i * n - j * m : j * m - i * n;
            if (offset >= d) begin
               node = 64'd0;
            end else begin
               prod = {64'd0, weight} * {64'd0, lattice_row[j]}
                      + (128'd1 << (DEF_FRAC_BITS - 1));
               node = prod[DEF_FRAC_BITS +: 64];
               if (j > 0) node = node + lattice_row[j - 1];
               if (node > Q_ONE) node = Q_ONE;
            end
            lattice_row[j] = node;
         end
      end
      prob = lattice_row[n];
      if (prob > Q_ONE) prob = Q_ONE;
      t = Q_ONE - prob;
      res.cdf     = prob[PROB_W-1:0];
      res.p_value = t[PROB_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type want;
      int              errs;
      int              pushed;
      int              popped;
      errs   = 0;
      pushed = 0;
      popped = 0;
      if (reset) begin
         cdf_expected_q.delete();
         outstanding    <= 0;
         mismatch_count <= 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (cdf_expected_q.size() == 0) begin
               $display("%0t unexpected response item: cdf %h p_value %h", $time,
                        rsp_chan.payload.cdf, rsp_chan.payload.p_value);
               errs++;
            end else begin
               want   = cdf_expected_q.pop_front();
               popped = 1;
               if (rsp_chan.payload.cdf !== want.cdf) begin
                  $display("%0t cdf mismatch: expected %h actual %h", $time,
                           want.cdf, rsp_chan.payload.cdf);
                  errs++;
               end
               if (rsp_chan.payload.p_value !== want.p_value) begin
                  $display("%0t p_value mismatch: expected %h actual %h", $time,
                           want.p_value, rsp_chan.payload.p_value);
                  errs++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            cdf_expected_q.insert(cdf_expected_q.size(), predict_cdf(req_chan.payload));
            pushed = 1;
         end
         outstanding    <= outstanding + pushed - popped;
         mismatch_count <= mismatch_count + errs;
      end
   end

endmodule

// File: tb/sv/tb_smirnov_two_sample_exact_cdf_unit.sv
// Testbench top for the exact Smirnov distribution unit: stimulus, flow control and verdict.
module tb_smirnov_two_sample_exact_cdf_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import stsecdf_pkg::*;

   localparam int STALL_LIMIT = 50000;

   typedef enum int {DRAIN_OPEN, DRAIN_RANDOM, DRAIN_SPARSE, DRAIN_HOLD} drain_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stsecdf_req_if req_chan ();
   stsecdf_rsp_if rsp_chan ();

   int             mismatch_count;
   int             outstanding;
   int             idle_cycles = 0;
   int             burst_left  = 0;
   int             gap;
   drain_mode_type drain_mode  = DRAIN_OPEN;
   int             drain_left  = 0;

   smirnov_two_sample_exact_cdf_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   smirnov_cdf_checker cdf_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The receiver switches between open, random, sparse and fully stalled stretches.
   always @(posedge clock) begin
      if (drain_left == 0) begin
         drain_mode = drain_mode_type'($urandom_range(0, 3));
         drain_left = $urandom_range(10, 300);
      end else begin
         drain_left--;
      end
      case (drain_mode)
         DRAIN_OPEN:   rsp_chan.ready <= 1'b1;
         DRAIN_RANDOM: rsp_chan.ready <= ($urandom_range(0, 1) == 1);
         DRAIN_SPARSE: rsp_chan.ready <= ($urandom_range(0, 7) == 0);
         default:      rsp_chan.ready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_smirnov_two_sample_exact_cdf_unit NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic offer_item(input int a, input int b, input int d);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{sample_count_a: COUNT_W'(a), sample_count_b: COUNT_W'(b),
                            statistic_scaled: STAT_W'(d)};
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin
      int a;
      int b;
      int d;
      int t;
      int kind;
      req_chan.valid   <= 1'b0;
      req_chan.payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Zero distance, minimal sizes, size zero and saturated sizes, largest distance.
      offer_item(1, 1, 0);
      offer_item(1, 1, 1);
      offer_item(1, 1, 2);
      offer_item(0, 0, 1);
      offer_item(0, 2047, 0);
      offer_item(2047, 2, 21'h1FFFFF);
      offer_item(1, 1024, 1024);
      offer_item(1025, 3, 1000);
      offer_item(1024, 1, 512);
      offer_item(2, 1024, 1);
      // Ordinary lattices, both orders of the sizes, distances on and beyond the corners.
      offer_item(3, 5, 7);
      offer_item(5, 3, 7);
      offer_item(4, 4, 4);
      offer_item(4, 4, 8);
      offer_item(4, 4, 16);
      offer_item(4, 4, 17);
      offer_item(10, 10, 30);
      offer_item(8, 12, 20);
      offer_item(20, 30, 600);
      offer_item(16, 16, 1);
      offer_item(6, 9, 18);
      offer_item(40, 48, 300);
      wait_for_results();

      for (int k = 0; k < 100; k++) begin
         if (k == 50) wait_for_results();
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            a = $urandom_range(1, 12);
            b = $urandom_range(1, 40);
            d = $urandom_range(0, a * b + 2);
         end else if (kind == 7) begin
            a = $urandom_range(1, 3);
            b = $urandom_range(0, 2047);
            d = $urandom_range(0, a * ((b > 1024) ? 1024 : b) + 4);
         end else if (kind == 8) begin
            a = $urandom_range(0, 6);
            b = $urandom_range(0, 2047);
            d = $urandom_range(0, 2097151);
         end else begin
            // Square lattices with distances that land exactly on lattice lines.
            a = $urandom_range(1, 24);
            b = a;
            d = b * $urandom_range(0, a + 1);
         end
         if ($urandom_range(0, 1) == 1) begin
            t = a;
            a = b;
            b = t;
         end
         offer_item(a, b, d);
      end

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tb_smirnov_two_sample_exact_cdf_unit OK");
      end else begin
         $display("tb_smirnov_two_sample_exact_cdf_unit NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/stsecdf_pkg.sv
src/stsecdf_if.sv
src/stsecdf_frac_div.sv
src/stsecdf_fx_mul.sv
src/smirnov_two_sample_exact_cdf_unit.sv
tb/sv/smirnov_cdf_checker.sv
tb/sv/tb_smirnov_two_sample_exact_cdf_unit.sv
